FILE: sv/cqnz_pkg.sv
package cqnz_pkg;

  localparam int LANES           = 4;
  localparam int COEF_W          = 16;
  localparam int MAG_W           = COEF_W + 1;
  localparam int SCALE_W         = 16;
  localparam int SHIFT_W         = 5;
  localparam int OFFSET_W        = 31;
  localparam int WORD_W          = 32;
  localparam int COUNT_W         = 11;
  localparam int MAX_BLOCK_COEFS = 1024;
  localparam int COUNT_MAX       = (1 << COUNT_W) - 1;
  localparam int COUNT_CAP       = (MAX_BLOCK_COEFS < COUNT_MAX) ? MAX_BLOCK_COEFS : COUNT_MAX;
  localparam int NZ_W            = $clog2(LANES + 1);
  localparam int CFG_IDX_W       = 2;
  localparam int CFG_DATA_W      = OFFSET_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_QUANT_SCALE  = 2'd0,
    CFG_QUANT_SHIFT  = 2'd1,
    CFG_ROUND_OFFSET = 2'd2
  } cfg_idx_e;

  typedef logic signed [COEF_W-1:0] coef_t;

  typedef struct packed {
    logic [SCALE_W-1:0]  scale;
    logic [SHIFT_W-1:0]  shift;
    logic [OFFSET_W-1:0] offset;
  } quant_cfg_t;

  // stage enables for the three lane pipeline stages
  typedef struct packed {
    logic en1;
    logic en2;
    logic en3;
  } lane_ctrl_t;

endpackage

FILE: sv/cqnz_lane.sv
module cqnz_lane (
  input  logic                  clk_i,
  input  cqnz_pkg::lane_ctrl_t  ctrl_i,
  input  cqnz_pkg::quant_cfg_t  cfg_i,
  input  cqnz_pkg::coef_t       coef_i,
  output cqnz_pkg::coef_t       level_o
);
  import cqnz_pkg::*;

  logic [MAG_W-1:0]         sext;
  logic [MAG_W-1:0]         mag;
  logic                     neg;
  logic [MAG_W+SCALE_W-1:0] prod_full;
  logic [WORD_W-1:0]        sum;
  logic [WORD_W-1:0]        shifted;
  logic [WORD_W-1:0]        signed_v;
  coef_t                    level_d;

  logic [WORD_W-1:0] prod_q;
  logic              neg1_q, zero1_q;
  logic [WORD_W-1:0] shr_q;
  logic              neg2_q, zero2_q;
  coef_t             level_q;

  always_comb begin
    neg       = coef_i[COEF_W-1];
    sext      = {coef_i[COEF_W-1], coef_i};
    mag       = neg ? (~sext + 1'b1) : sext;
    prod_full = mag * cfg_i.scale;
  end

  // wraps modulo 2^32, then shifts as a signed word
  always_comb begin
    sum     = prod_q + WORD_W'(cfg_i.offset);
    shifted = $signed(sum) >>> cfg_i.shift;
  end

  always_comb begin
    signed_v = neg2_q ? (~shr_q + 1'b1) : shr_q;
    if (zero2_q) begin
      level_d = '0;
    end else if (signed_v[WORD_W-1] && !(&signed_v[WORD_W-1:COEF_W-1])) begin
      level_d = {1'b1, {(COEF_W-1){1'b0}}};
    end else if (!signed_v[WORD_W-1] && (|signed_v[WORD_W-2:COEF_W-1])) begin
      level_d = {1'b0, {(COEF_W-1){1'b1}}};
    end else begin
      level_d = signed_v[COEF_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en1) begin
      prod_q  <= prod_full[WORD_W-1:0];
      neg1_q  <= neg;
      zero1_q <= (coef_i == '0);
    end
    if (ctrl_i.en2) begin
      shr_q   <= shifted;
      neg2_q  <= neg1_q;
      zero2_q <= zero1_q;
    end
    if (ctrl_i.en3) begin
      level_q <= level_d;
    end
  end

  assign level_o = level_q;

endmodule

FILE: sv/cqnz_merge.sv
module cqnz_merge (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  input  cqnz_pkg::coef_t [cqnz_pkg::LANES-1:0] level_i,
  input  logic                                  last_i,
  output logic                                  take_o,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output cqnz_pkg::coef_t [cqnz_pkg::LANES-1:0] level_o,
  output logic                                  last_o,
  output logic [cqnz_pkg::COUNT_W-1:0]          total_o
);
  import cqnz_pkg::*;

  logic [NZ_W-1:0]    nz;
  logic [COUNT_W:0]   sum;
  logic [COUNT_W-1:0] capped;

  logic                   out_valid_q;
  logic [COUNT_W-1:0]     running_q;
  coef_t [LANES-1:0]      level_q;
  logic                   last_q;
  logic [COUNT_W-1:0]     total_q;

  always_comb begin
    nz = '0;
    for (int k = 0; k < LANES; k++) begin
      nz = nz + NZ_W'(level_i[k] != '0);
    end
    sum = {1'b0, running_q} + (COUNT_W+1)'(nz);
    // running count stops at the cap rather than wrapping
    if (sum > (COUNT_W+1)'(COUNT_CAP)) begin
      capped = COUNT_W'(COUNT_CAP);
    end else begin
      capped = sum[COUNT_W-1:0];
    end
  end

  assign take_o = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      running_q   <= '0;
    end else if (take_o) begin
      out_valid_q <= in_valid_i;
      if (in_valid_i) begin
        running_q <= last_i ? '0 : capped;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o && in_valid_i) begin
      level_q <= level_i;
      last_q  <= last_i;
      total_q <= last_i ? capped : '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign level_o     = level_q;
  assign last_o      = last_q;
  assign total_o     = total_q;

endmodule

FILE: sv/coefficient_quantizer_nonzero_count_core.sv
// Quantizes four signed 16-bit coefficients per transfer and counts nonzero levels
// over a block. One transfer is accepted every cycle unless a stall fills every
// stage. Each result passes three pipeline stages in each lane (multiply, add and
// shift, sign and saturate) and one merge stage that holds the output register and
// the running count. Every stage holds its own valid bit, so in_ready_o stays high
// while a waiting result is stalled as long as any stage is empty. The total is
// given on the result marked last and is zero on every other result.
module coefficient_quantizer_nonzero_count_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [cqnz_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [cqnz_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic signed [cqnz_pkg::COEF_W-1:0] coef_lane0_i,
  input  logic signed [cqnz_pkg::COEF_W-1:0] coef_lane1_i,
  input  logic signed [cqnz_pkg::COEF_W-1:0] coef_lane2_i,
  input  logic signed [cqnz_pkg::COEF_W-1:0] coef_lane3_i,
  input  logic                               block_last_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [cqnz_pkg::COEF_W-1:0] level_lane0_o,
  output logic signed [cqnz_pkg::COEF_W-1:0] level_lane1_o,
  output logic signed [cqnz_pkg::COEF_W-1:0] level_lane2_o,
  output logic signed [cqnz_pkg::COEF_W-1:0] level_lane3_o,
  output logic                               result_last_o,
  output logic [cqnz_pkg::COUNT_W-1:0]       nonzero_total_o
);
  import cqnz_pkg::*;

  quant_cfg_t        cfg_q;
  lane_ctrl_t        ctrl;
  coef_t [LANES-1:0] coef;
  coef_t [LANES-1:0] lane_level;
  coef_t [LANES-1:0] out_level;
  logic              take;
  logic              v1_q, v2_q, v3_q;
  logic              last1_q, last2_q, last3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_QUANT_SCALE:  cfg_q.scale  <= cfg_wdata_i[SCALE_W-1:0];
        CFG_QUANT_SHIFT:  cfg_q.shift  <= cfg_wdata_i[SHIFT_W-1:0];
        CFG_ROUND_OFFSET: cfg_q.offset <= cfg_wdata_i[OFFSET_W-1:0];
        default: ;
      endcase
    end
  end

  // a stage moves on when the next one is empty or moving
  always_comb begin
    ctrl.en3 = !v3_q || take;
    ctrl.en2 = !v2_q || ctrl.en3;
    ctrl.en1 = !v1_q || ctrl.en2;
  end

  assign in_ready_o = ctrl.en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (ctrl.en1) v1_q <= in_valid_i;
      if (ctrl.en2) v2_q <= v1_q;
      if (ctrl.en3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.en1) last1_q <= block_last_i;
    if (ctrl.en2) last2_q <= last1_q;
    if (ctrl.en3) last3_q <= last2_q;
  end

  assign coef[0] = coef_lane0_i;
  assign coef[1] = coef_lane1_i;
  assign coef[2] = coef_lane2_i;
  assign coef[3] = coef_lane3_i;

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    cqnz_lane u_lane (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .cfg_i   (cfg_q),
      .coef_i  (coef[g]),
      .level_o (lane_level[g])
    );
  end

  cqnz_merge u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (v3_q),
    .level_i     (lane_level),
    .last_i      (last3_q),
    .take_o      (take),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .level_o     (out_level),
    .last_o      (result_last_o),
    .total_o     (nonzero_total_o)
  );

  assign level_lane0_o = out_level[0];
  assign level_lane1_o = out_level[1];
  assign level_lane2_o = out_level[2];
  assign level_lane3_o = out_level[3];

`ifndef SYNTH
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with no result waiting");

  a_total_only_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !result_last_o) |-> (nonzero_total_o == '0))
    else $error("nonzero total outside the last transfer");

  a_total_capped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (nonzero_total_o <= COUNT_W'(COUNT_CAP)))
    else $error("nonzero total above cap");

  a_accept_fills_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> v1_q)
    else $error("accepted transfer lost at first stage");
`endif

endmodule

FILE: tb/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import cqnz_pkg::*;

  localparam int QUIET_LIMIT = 1000;

  typedef struct {
    coef_t coef [LANES];
    logic  last;
  } coef_group_t;

  typedef struct {
    coef_t              level [LANES];
    logic               last;
    logic [COUNT_W-1:0] total;
  } level_group_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_ready_o;
  coef_t                 coef_lane0_i = '0;
  coef_t                 coef_lane1_i = '0;
  coef_t                 coef_lane2_i = '0;
  coef_t                 coef_lane3_i = '0;
  logic                  block_last_i = 1'b0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  coef_t                 level_lane0_o;
  coef_t                 level_lane1_o;
  coef_t                 level_lane2_o;
  coef_t                 level_lane3_o;
  logic                  result_last_o;
  logic [COUNT_W-1:0]    nonzero_total_o;

  // quantizer settings and running count as the block should hold them
  logic [SCALE_W-1:0]  scale_q;
  logic [SHIFT_W-1:0]  shift_q;
  logic [OFFSET_W-1:0] offset_q;
  logic [COUNT_W-1:0]  nz_running;

  coef_group_t  coef_groups_pending [$];
  level_group_t levels_awaited [$];
  int           groups_queued = 0;
  int           groups_taken  = 0;
  int           mismatches    = 0;
  int           quiet_cycles  = 0;
  int           in_gap        = 0;
  int           out_gap       = 0;
  bit           idling_on     = 1'b1;

  coefficient_quantizer_nonzero_count_core i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .coef_lane0_i    (coef_lane0_i),
    .coef_lane1_i    (coef_lane1_i),
    .coef_lane2_i    (coef_lane2_i),
    .coef_lane3_i    (coef_lane3_i),
    .block_last_i    (block_last_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .level_lane0_o   (level_lane0_o),
    .level_lane1_o   (level_lane1_o),
    .level_lane2_o   (level_lane2_o),
    .level_lane3_o   (level_lane3_o),
    .result_last_o   (result_last_o),
    .nonzero_total_o (nonzero_total_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic coef_t quant_level(coef_t c);
    logic [MAG_W-1:0]         mag;
    logic [WORD_W-1:0]        word;
    logic signed [WORD_W-1:0] lvl;
    if (c == 0) begin
      return '0;
    end
    mag = c[COEF_W-1] ? (MAG_W'(1) << COEF_W) - {1'b0, c} : {1'b0, c};
    // product and offset wrap at 32 bits
    word = WORD_W'(mag) * WORD_W'(scale_q);
    word = word + WORD_W'(offset_q);
    lvl = $signed(word) >>> shift_q;
    if (c[COEF_W-1]) begin
      lvl = -lvl;
    end
    if (lvl > 32'sd32767) begin
      return 16'sh7fff;
    end
    if (lvl < -32'sd32768) begin
      return 16'sh8000;
    end
    return lvl[COEF_W-1:0];
  endfunction

  function automatic level_group_t quantize_group(coef_group_t g);
    level_group_t       r;
    logic [COUNT_W-1:0] cnt;
    cnt = nz_running;
    for (int k = 0; k < LANES; k++) begin
      r.level[k] = quant_level(g.coef[k]);
      if (r.level[k] != 0 && cnt < COUNT_W'(COUNT_CAP)) begin
        cnt++;
      end
    end
    r.last  = g.last;
    r.total = g.last ? cnt : '0;
    nz_running = g.last ? '0 : cnt;
    return r;
  endfunction

  function automatic coef_t pick_coef();
    int v;
    case ($urandom_range(0, 9))
      0: return '0;
      1: return 16'sh8000;
      2: return 16'sh7fff;
      3: return $urandom_range(0, 1) ? 16'sh0001 : 16'shffff;
      4, 5: begin
        v = $urandom_range(0, 255);
        return $urandom_range(0, 1) ? coef_t'(v) : -coef_t'(v);
      end
      default: return coef_t'($urandom());
    endcase
  endfunction

  task automatic push_group(coef_t c0, coef_t c1, coef_t c2, coef_t c3, logic last);
    coef_group_t g;
    g.coef[0] = c0;
    g.coef[1] = c1;
    g.coef[2] = c2;
    g.coef[3] = c3;
    g.last    = last;
    coef_groups_pending.push_back(g);
    groups_queued++;
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    case (idx)
      CFG_QUANT_SCALE:  scale_q  = data[SCALE_W-1:0];
      CFG_QUANT_SHIFT:  shift_q  = data[SHIFT_W-1:0];
      CFG_ROUND_OFFSET: offset_q = data[OFFSET_W-1:0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic drain();
    while (groups_taken != groups_queued || levels_awaited.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (6) @(posedge clk_i);
  endtask

  // upper data bits above each register are junk and must be ignored
  task automatic set_quant(logic [SCALE_W-1:0] scale, logic [SHIFT_W-1:0] shift,
                           logic [OFFSET_W-1:0] offset);
    drain();
    write_reg(CFG_QUANT_SCALE, {15'($urandom()), scale});
    write_reg(CFG_QUANT_SHIFT, {26'($urandom()), shift});
    write_reg(CFG_ROUND_OFFSET, offset);
  endtask

  task automatic queue_blocks(int n_items, int max_len);
    int left;
    left = 0;
    for (int i = 0; i < n_items; i++) begin
      if (left == 0) begin
        left = $urandom_range(1, max_len);
      end
      push_group(pick_coef(), pick_coef(), pick_coef(), pick_coef(),
                 left == 1 || i == n_items - 1);
      left--;
    end
  endtask

  task automatic pick_quant();
    logic [SCALE_W-1:0]  scale;
    logic [SHIFT_W-1:0]  shift;
    logic [OFFSET_W-1:0] offset;
    case ($urandom_range(0, 3))
      0: begin
        scale  = SCALE_W'($urandom_range(1, 65535));
        shift  = SHIFT_W'($urandom_range(8, 20));
        offset = $urandom_range(0, 1) ? (31'd1 << shift) >> 1
                                      : 31'($urandom_range(0, (1 << shift) - 1));
      end
      1: begin
        scale  = SCALE_W'($urandom());
        shift  = SHIFT_W'($urandom());
        offset = OFFSET_W'($urandom());
      end
      2: begin
        scale  = $urandom_range(0, 1) ? 16'hffff : 16'h0000;
        shift  = $urandom_range(0, 1) ? 5'd31 : 5'd0;
        offset = $urandom_range(0, 1) ? 31'h7fffffff : 31'h0;
      end
      default: begin
        scale  = SCALE_W'($urandom_range(0, 15));
        shift  = SHIFT_W'($urandom_range(0, 4));
        offset = OFFSET_W'($urandom_range(0, 7));
      end
    endcase
    set_quant(scale, shift, offset);
  endtask

  // driver: one transfer per handshake, payload held while stalled
  always @(posedge clk_i) begin
    coef_group_t g;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        g.coef[0] = coef_lane0_i;
        g.coef[1] = coef_lane1_i;
        g.coef[2] = coef_lane2_i;
        g.coef[3] = coef_lane3_i;
        g.last    = block_last_i;
        levels_awaited.push_back(quantize_group(g));
        groups_taken++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid_i <= 1'b0;
        end else if (idling_on && $urandom_range(0, 15) == 0) begin
          in_gap = $urandom_range(0, 15);
          in_valid_i <= 1'b0;
        end else if (coef_groups_pending.size() > 0) begin
          g = coef_groups_pending.pop_front();
          coef_lane0_i <= g.coef[0];
          coef_lane1_i <= g.coef[1];
          coef_lane2_i <= g.coef[2];
          coef_lane3_i <= g.coef[3];
          block_last_i <= g.last;
          in_valid_i   <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each result transfer with the oldest prediction
  always @(posedge clk_i) begin
    level_group_t got;
    level_group_t want;
    bit           bad;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        got.level[0] = level_lane0_o;
        got.level[1] = level_lane1_o;
        got.level[2] = level_lane2_o;
        got.level[3] = level_lane3_o;
        got.last     = result_last_o;
        got.total    = nonzero_total_o;
        if (levels_awaited.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: unexpected result levels %0d %0d %0d %0d last %b total %0d",
                     $realtime, got.level[0], got.level[1], got.level[2], got.level[3],
                     got.last, got.total);
          end
        end else begin
          want = levels_awaited.pop_front();
          bad = 1'b0;
          for (int k = 0; k < LANES; k++) begin
            if (got.level[k] !== want.level[k]) begin
              bad = 1'b1;
            end
          end
          if (got.last !== want.last || got.total !== want.total) begin
            bad = 1'b1;
          end
          if (bad) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: mismatch expected %0d %0d %0d %0d last %b total %0d",
                       $realtime, want.level[0], want.level[1], want.level[2],
                       want.level[3], want.last, want.total);
              $display("%0t:          actual   %0d %0d %0d %0d last %b total %0d",
                       $realtime, got.level[0], got.level[1], got.level[2],
                       got.level[3], got.last, got.total);
            end
          end
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_ready_i <= 1'b0;
      end else if (idling_on && $urandom_range(0, 15) == 0) begin
        out_gap = $urandom_range(0, 15);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin
    scale_q    = '0;
    shift_q    = '0;
    offset_q   = '0;
    nz_running = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: every level is zero
    push_group(16'sh7fff, 16'sh8000, 16'sh0000, 16'shffff, 1'b0);
    push_group(16'sh0001, 16'sh8000, 16'sh7fff, 16'sh0000, 1'b1);

    // unit scale passes coefficients through, most negative included
    set_quant(16'd1, 5'd0, 31'd0);
    push_group(16'sh8000, 16'sh7fff, 16'sh0000, 16'sh0001, 1'b0);
    push_group(16'shffff, 16'sh0000, 16'sh0000, 16'sh0000, 1'b1);
    push_group(16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 1'b1);
    push_group(16'sh5555, 16'shaaaa, 16'sh00ff, 16'shff00, 1'b1);

    // wide products wrap and shift as negative words
    set_quant(16'hffff, 5'd31, 31'h7fffffff);
    push_group(16'sh8000, 16'sh7fff, 16'sh0001, 16'shffff, 1'b1);
    push_group(16'sh0002, 16'shfffe, 16'sh0000, 16'sh3039, 1'b0);
    push_group(16'sh4000, 16'shc000, 16'sh8001, 16'sh7ffe, 1'b1);

    // saturation at both ends
    set_quant(16'hffff, 5'd0, 31'h7fffffff);
    push_group(16'sh8000, 16'sh7fff, 16'sh0001, 16'shffff, 1'b0);
    push_group(16'shfffe, 16'sh0003, 16'sh0064, 16'shff9c, 1'b1);

    // rounding with a small shift
    set_quant(16'd3, 5'd1, 31'd1);
    push_group(16'sh8000, 16'sh7fff, 16'sh0001, 16'shffff, 1'b0);
    push_group(16'sh0002, 16'shfffd, 16'sh0000, 16'sh0005, 1'b1);

    // overlong block: the running count has to stop at the cap
    set_quant(16'hffff, 5'd0, 31'd0);
    for (int i = 0; i < 300; i++) begin
      push_group(16'sh0001 + coef_t'($urandom_range(0, 100)), 16'sh8000,
                 -coef_t'($urandom_range(1, 32767)), 16'sh7fff, i == 299);
    end

    for (int p = 0; p < 8; p++) begin
      pick_quant();
      if (p >= 6) begin
        idling_on = 1'b0;
      end
      queue_blocks(160, (p % 2 == 0) ? 8 : 40);
    end

    while (groups_taken != groups_queued || levels_awaited.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && levels_awaited.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
